[hdl/prmd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse run merge decoder package
// Shared constants, register indexes and the command/status bundles between
// the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
package prmd_pkg;

   // Signed microsecond result width
   localparam int DUR_W = 27;

   // Ticks-per-ten-microseconds value: at most 800, so ten bits
   localparam int TPT_W = 10;
   localparam int TPT_NUMER = 800;

   // Configuration register widths and reset values
   localparam int DIVIDER_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [DIVIDER_W-1:0] RESET_DIVIDER = 8'd80;
   localparam logic [TPT_W-1:0] RESET_TPT = 10'd10;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_DIVIDER = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_INPUT = 1'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;    // latch the accepted request
      logic div_tpt;     // start 800 / divider
      logic load_tpt;    // store the finished ticks-per-ten-us quotient
      logic apply_half;  // merge the selected half into the pending run
      logic half_sel;    // 0: first half, 1: second half
      logic div_conv;    // capture pending run and start its conversion
      logic conv_fend;   // frame-end mark for the captured run
      logic clear_run;   // drop the pending run
      logic push_conv;   // load the converted duration into the output stage
      logic push_zero;   // load a zero-duration frame-end result
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic emit_pending; // selected half ends a nonempty run
      logic run_nonzero;  // a run is pending
      logic frame_last;   // latched request closes the frame
      logic tpt_stale;    // divider was rewritten since the last quotient
      logic div_busy;
      logic div_done;
      logic out_free;     // output stage can take a result this cycle
   } dp_sts_type;

endpackage
`default_nettype wire

[hdl/prmd_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle. The quotient is shifted in
// place of the dividend and stays valid after done until the next start.
// ----------------------------------------------------------------------------
module prmd_div
   import prmd_pkg::*;
#(
   parameter int DVD_W = 28
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [TPT_W-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [TPT_W-1:0] rem_ff, rem_in;
   logic [TPT_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [TPT_W:0] trial;
   logic [TPT_W:0] diff;
   logic           qbit;

   // Trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      qbit  = (trial >= {1'b0, dsr_ff});
   end

   // Advance one quotient bit per cycle
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], qbit};
         rem_in  = qbit ? diff[TPT_W-1:0] : trial[TPT_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
`default_nettype wire

[hdl/prmd_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse run merge datapath
// Holds configuration, the latched request, the pending run, the shared
// divider and the result output stage. Acts on commands and CSR writes.
// ----------------------------------------------------------------------------
module prmd_dp
   import prmd_pkg::*;
#(
   parameter int RUN_TICK_WIDTH  = 24,
   parameter int HALF_TICK_WIDTH = 15
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                       req_first_level,
   input  wire logic [HALF_TICK_WIDTH-1:0] req_first_ticks,
   input  wire logic                       req_second_level,
   input  wire logic [HALF_TICK_WIDTH-1:0] req_second_ticks,
   input  wire logic                       req_frame_last,
   input  wire dp_cmd_type                 cmd,
   output dp_sts_type                      sts,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic signed [DUR_W-1:0]         rsp_duration_us,
   output logic                            rsp_frame_end
);

   localparam int RUN_W = RUN_TICK_WIDTH;
   localparam int HALF_W = HALF_TICK_WIDTH;
   localparam int DVD_W = RUN_W + 4;

   // Configuration
   logic [DIVIDER_W-1:0] divider_ff, divider_in;
   logic                 invert_ff, invert_in;
   logic [TPT_W-1:0]     tpt_ff, tpt_in;
   logic                 stale_ff, stale_in;

   // Latched request
   logic              lv0_ff, lv1_ff, last_ff;
   logic [HALF_W-1:0] t0_ff, t1_ff;

   // Pending run and the run under conversion
   logic             run_level_ff, run_level_in;
   logic [RUN_W-1:0] run_ticks_ff, run_ticks_in;
   logic             conv_level_ff, conv_fend_ff;

   // Output stage
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DUR_W-1:0] rsp_dur_ff, rsp_dur_in;
   logic                    rsp_fend_ff, rsp_fend_in;

   logic              h_level;
   logic [HALF_W-1:0] h_ticks;
   logic [RUN_W:0]    h_ext;
   logic [RUN_W:0]    sum;
   logic [RUN_W-1:0]  sat;
   logic              run_nonzero;
   logic              out_free;

   logic [DVD_W-1:0]  run_x;
   logic [DVD_W-1:0]  ticks10;
   logic [DIVIDER_W-1:0] div_eff;
   logic              div_start;
   logic [DVD_W-1:0]  div_dividend;
   logic [TPT_W-1:0]  div_divisor;
   logic              div_busy, div_done;
   logic [DVD_W-1:0]  quotient;
   logic [DVD_W+DUR_W-1:0] q_ext;
   logic [DUR_W-1:0]  mag;
   logic              neg;

   // Select and merge a half
   always_comb begin
      h_level     = cmd.half_sel ? lv1_ff : lv0_ff;
      h_ticks     = cmd.half_sel ? t1_ff : t0_ff;
      h_ext       = {{(RUN_W + 1 - HALF_W){1'b0}}, h_ticks};
      sum         = {1'b0, run_ticks_ff} + h_ext;
      sat         = sum[RUN_W] ? {RUN_W{1'b1}} : sum[RUN_W-1:0];
      run_nonzero = (run_ticks_ff != '0);
   end

   // Divider operands: 800 / divider, or ticks * 10 / tpt
   always_comb begin
      div_eff      = (divider_ff == '0) ? DIVIDER_W'(1) : divider_ff;
      run_x        = {4'b0000, run_ticks_ff};
      ticks10      = (run_x << 3) + (run_x << 1);
      div_start    = cmd.div_tpt | cmd.div_conv;
      div_dividend = cmd.div_tpt ? DVD_W'(TPT_NUMER) : ticks10;
      div_divisor  = cmd.div_tpt ? {{(TPT_W - DIVIDER_W){1'b0}}, div_eff} : tpt_ff;
   end

   prmd_div #(
      .DVD_W(DVD_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(quotient)
   );

   // Signed duration from the quotient, wrapped to the result width
   always_comb begin
      q_ext = {{DUR_W{1'b0}}, quotient};
      mag   = q_ext[DUR_W-1:0];
      neg   = (conv_level_ff == 1'b0) != invert_ff;
   end

   // Configuration writes and tpt refresh
   always_comb begin
      divider_in = divider_ff;
      invert_in  = invert_ff;
      tpt_in     = tpt_ff;
      stale_in   = stale_ff;
      if (cmd.load_tpt) begin
         tpt_in   = quotient[TPT_W-1:0];
         stale_in = 1'b0;
      end
      if (csr_write_en) begin
         case (csr_index)
            CSR_CLOCK_DIVIDER: begin
               divider_in = csr_wdata[DIVIDER_W-1:0];
               stale_in   = 1'b1;
            end
            CSR_INVERT_INPUT: begin
               invert_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pending run update
   always_comb begin
      run_level_in = run_level_ff;
      run_ticks_in = run_ticks_ff;
      if (cmd.clear_run) begin
         run_level_in = 1'b0;
         run_ticks_in = '0;
      end else if (cmd.apply_half) begin
         if (h_level == run_level_ff) begin
            run_ticks_in = sat;
         end else begin
            run_level_in = h_level;
            run_ticks_in = h_ext[RUN_W-1:0];
         end
      end
   end

   // Output stage: load a result or drop the taken one
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff;
      rsp_dur_in   = rsp_dur_ff;
      rsp_fend_in  = rsp_fend_ff;
      if (cmd.push_conv) begin
         rsp_valid_in = 1'b1;
         rsp_dur_in   = neg ? (DUR_W'(0) - mag) : mag;
         rsp_fend_in  = conv_fend_ff;
      end else if (cmd.push_zero) begin
         rsp_valid_in = 1'b1;
         rsp_dur_in   = '0;
         rsp_fend_in  = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= RESET_DIVIDER;
         invert_ff    <= 1'b0;
         tpt_ff       <= RESET_TPT;
         stale_ff     <= 1'b0;
         run_level_ff <= 1'b0;
         run_ticks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         divider_ff   <= divider_in;
         invert_ff    <= invert_in;
         tpt_ff       <= tpt_in;
         stale_ff     <= stale_in;
         run_level_ff <= run_level_in;
         run_ticks_ff <= run_ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_req) begin
         lv0_ff  <= req_first_level;
         t0_ff   <= req_first_ticks;
         lv1_ff  <= req_second_level;
         t1_ff   <= req_second_ticks;
         last_ff <= req_frame_last;
      end
      if (cmd.div_conv) begin
         conv_level_ff <= run_level_ff;
         conv_fend_ff  <= cmd.conv_fend;
      end
      rsp_dur_ff  <= rsp_dur_in;
      rsp_fend_ff <= rsp_fend_in;
   end

   always_comb begin
      sts.emit_pending = (h_level != run_level_ff) && run_nonzero;
      sts.run_nonzero  = run_nonzero;
      sts.frame_last   = last_ff;
      sts.tpt_stale    = stale_ff;
      sts.div_busy     = div_busy;
      sts.div_done     = div_done;
      sts.out_free     = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duration_us = rsp_dur_ff;
   assign rsp_frame_end   = rsp_fend_ff;

endmodule
`default_nettype wire

[hdl/prmd_ctl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse run merge controller
// Sequences one request: optional tpt refresh, first half, second half and
// frame close, each emitted run going through the shared divider.
// ----------------------------------------------------------------------------
module prmd_ctl
   import prmd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_TPT,
      S_TPT_WAIT,
      S_HALF0,
      S_HALF1,
      S_LAST,
      S_CONV,
      S_PUSH,
      S_ZERO
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = sts.tpt_stale ? S_TPT : S_HALF0;
            end
         end
         S_TPT: begin
            cmd.div_tpt = 1'b1;
            state_in    = S_TPT_WAIT;
         end
         S_TPT_WAIT: begin
            if (sts.div_done) begin
               cmd.load_tpt = 1'b1;
               state_in     = S_HALF0;
            end
         end
         S_HALF0, S_HALF1: begin
            cmd.half_sel   = (state_ff == S_HALF1);
            cmd.apply_half = 1'b1;
            if (sts.emit_pending) begin
               cmd.div_conv = 1'b1;
               ret_in       = (state_ff == S_HALF1) ? S_LAST : S_HALF1;
               state_in     = S_CONV;
            end else begin
               state_in = (state_ff == S_HALF1) ? S_LAST : S_HALF1;
            end
         end
         S_LAST: begin
            if (!sts.frame_last) begin
               state_in = S_IDLE;
            end else if (sts.run_nonzero) begin
               cmd.div_conv  = 1'b1;
               cmd.conv_fend = 1'b1;
               cmd.clear_run = 1'b1;
               ret_in        = S_IDLE;
               state_in      = S_CONV;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_CONV: begin
            if (sts.div_done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (sts.out_free) begin
               cmd.push_conv = 1'b1;
               state_in      = ret_ff;
            end
         end
         S_ZERO: begin
            if (sts.out_free) begin
               cmd.push_zero = 1'b1;
               cmd.clear_run = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // A result is never loaded over one that is still waiting
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_conv || cmd.push_zero) |-> sts.out_free)
      else $error("result loaded into a full output stage");

   // The shared divider is started only when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_conv || cmd.div_tpt) |-> !sts.div_busy)
      else $error("divider restarted while busy");

   // No division is left running once the request is finished
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sts.div_busy)
      else $error("divider busy while controller idle");

   // A conversion result waiting in S_PUSH is pushed and the state left once the output stage is free
   a_conv_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && sts.out_free) |=> (state_ff != S_PUSH || ret_ff == S_PUSH))
      else $error("conversion result not pushed");

endmodule
`default_nettype wire

[hdl/pulse_run_merge_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse run merge decoder
// Merges captured level/duration halves into runs and emits each finished
// run as a signed microsecond duration, flushing at frame end.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle and is worked through one
// half after the other. Every emitted run is converted by one shared
// restoring divider that yields one quotient bit per cycle. A request emits
// from zero to three converted runs, and a zero-duration frame end when it
// closes a frame with nothing pending. On the first request after the
// divider register is written, ticks per ten microseconds (800 / divider) is
// first recomputed on the same divider. A finished result waits in an output
// register while the next one is worked on; the block holds only when that
// register is full.
// ----------------------------------------------------------------------------
module pulse_run_merge_decoder
   import prmd_pkg::*;
#(
   parameter int RUN_TICK_WIDTH  = 24,
   parameter int HALF_TICK_WIDTH = 15
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_first_level,
   input  wire logic [HALF_TICK_WIDTH-1:0] req_first_ticks,
   input  wire logic                       req_second_level,
   input  wire logic [HALF_TICK_WIDTH-1:0] req_second_ticks,
   input  wire logic                       req_frame_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [DUR_W-1:0]         rsp_duration_us,
   output logic                            rsp_frame_end
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   prmd_ctl u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   prmd_dp #(
      .RUN_TICK_WIDTH (RUN_TICK_WIDTH),
      .HALF_TICK_WIDTH(HALF_TICK_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_first_level (req_first_level),
      .req_first_ticks (req_first_ticks),
      .req_second_level(req_second_level),
      .req_second_ticks(req_second_ticks),
      .req_frame_last  (req_frame_last),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_duration_us (rsp_duration_us),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule
`default_nettype wire
